@@ src/mcrm_pkg.sv @@
// Shared types, register indexes, codes and constants for the MIDI control range mapper.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package mcrm_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgInLow        = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgInHigh       = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgOutLow       = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgOutHigh      = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgMatchType    = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgMatchChannel = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgMatchNumber  = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgOutputMode   = 4'd7;

  // Register reset values
  localparam logic [15:0]        RstInLow        = 16'd0;
  localparam logic [15:0]        RstInHigh       = 16'd127;
  localparam logic signed [31:0] RstOutLow       = 32'sd0;
  localparam logic signed [31:0] RstOutHigh      = 32'sd65536;
  localparam logic [1:0]         RstMatchType    = 2'd0;
  localparam logic [4:0]         RstMatchChannel = 5'd1;
  localparam logic [6:0]         RstMatchNumber  = 7'd0;
  localparam logic [2:0]         RstOutputMode   = 3'd0;

  // Learned input ranges
  localparam logic [15:0] LearnHighCtl   = 16'd127;
  localparam logic [15:0] LearnHighPitch = 16'd65535;

  // Q16.16 one
  localparam logic signed [31:0] OneQ16 = 32'sd65536;

  // MIDI commands
  localparam logic [1:0] CmdNoteOn  = 2'd0;
  localparam logic [1:0] CmdNoteOff = 2'd1;
  localparam logic [1:0] CmdCtl     = 2'd2;
  localparam logic [1:0] CmdPitch   = 2'd3;

  // Match types
  localparam logic [1:0] MatchCtl   = 2'd0;
  localparam logic [1:0] MatchNote  = 2'd1;
  localparam logic [1:0] MatchPitch = 2'd2;
  localparam logic [1:0] MatchLearn = 2'd3;

  // Output modes
  localparam logic [2:0] ModeNumber  = 3'd0;
  localparam logic [2:0] ModeTrigger = 3'd1;
  localparam logic [2:0] ModeBoolAny = 3'd2;
  localparam logic [2:0] ModeBoolPos = 3'd3;
  localparam logic [2:0] ModeBoolOne = 3'd4;
  localparam logic [2:0] ModeTogAny  = 3'd5;
  localparam logic [2:0] ModeTogPos  = 3'd6;
  localparam logic [2:0] ModeTogOne  = 3'd7;

  // Write kinds
  localparam logic [1:0] KindNumber  = 2'd0;
  localparam logic [1:0] KindTrigger = 2'd1;
  localparam logic [1:0] KindBool    = 2'd2;

  // Mapping datapath widths
  localparam int unsigned NumW     = 50;            // signed product width
  localparam int unsigned DivSteps = NumW / 2;      // two quotient bits per cycle
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  midi_channel;
    logic [6:0]  note_or_controller;
    logic [15:0] event_value;
  } mcrm_in_t;

  typedef struct packed {
    logic [1:0]         write_kind;
    logic signed [31:0] number_value;
    logic               bool_value;
  } mcrm_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic learn;
    logic load_ops;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic div_init;
    logic div_step;
    logic negate;
    logic add;
    logic clamp;
    logic commit;
  } mcrm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic div_last;
    logic out_free;
  } mcrm_stat_t;

  typedef enum logic [3:0] {
    StIdle,
    StLearn,
    StCheck,
    StMulLo,
    StMulHi,
    StSum,
    StDivInit,
    StDiv,
    StNegate,
    StAdd,
    StClamp,
    StDecide
  } mcrm_state_e;

endpackage

@@ src/mcrm_ctrl.sv @@
// Sequencing state machine of the MIDI control range mapper.
// Depends on mcrm_pkg; drives the command struct of mcrm_dp.
`timescale 1ns / 1ps

module mcrm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mcrm_pkg::mcrm_stat_t stat_i,
  output mcrm_pkg::mcrm_cmd_t  cmd_o
);
  import mcrm_pkg::*;

  mcrm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StLearn;
      end
      StLearn:   state_d = StCheck;
      StCheck: begin
        // drop events that miss the active match
        state_d = stat_i.hit ? StMulLo : StIdle;
      end
      StMulLo:   state_d = StMulHi;
      StMulHi:   state_d = StSum;
      StSum:     state_d = StDivInit;
      StDivInit: state_d = StDiv;
      StDiv: begin
        if (stat_i.div_last) state_d = StNegate;
      end
      StNegate:  state_d = StAdd;
      StAdd:     state_d = StClamp;
      StClamp:   state_d = StDecide;
      StDecide: begin
        // hold until the output register can take the transaction
        if (stat_i.out_free) state_d = StIdle;
      end
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      StLearn:   cmd_o.learn    = 1'b1;
      StCheck:   cmd_o.load_ops = 1'b1;
      StMulLo:   cmd_o.mul_lo   = 1'b1;
      StMulHi:   cmd_o.mul_hi   = 1'b1;
      StSum:     cmd_o.sum      = 1'b1;
      StDivInit: cmd_o.div_init = 1'b1;
      StDiv:     cmd_o.div_step = 1'b1;
      StNegate:  cmd_o.negate   = 1'b1;
      StAdd:     cmd_o.add      = 1'b1;
      StClamp:   cmd_o.clamp    = 1'b1;
      StDecide:  cmd_o.commit   = stat_i.out_free;
      default:   cmd_o          = '0;
    endcase
  end

endmodule

@@ src/mcrm_dp.sv @@
// Datapath of the MIDI control range mapper: registers, match, multiply, divide, clamp, output.
// Depends on mcrm_pkg; sequenced by mcrm_ctrl through mcrm_cmd_t / mcrm_stat_t.
`timescale 1ns / 1ps

module mcrm_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mcrm_pkg::mcrm_cmd_t            cmd_i,
  output mcrm_pkg::mcrm_stat_t           stat_o,
  input  mcrm_pkg::mcrm_in_t             in_data_i,
  input  logic                           cfg_we_i,
  input  logic [mcrm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mcrm_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mcrm_pkg::mcrm_out_t            out_data_o
);
  import mcrm_pkg::*;

  // Configuration and active match
  logic signed [31:0] out_low_q, out_high_q;
  logic [2:0]         mode_q;
  logic [15:0]        act_in_low_q, act_in_high_q;
  logic [1:0]         act_type_q;
  logic [4:0]         act_channel_q;
  logic [6:0]         act_number_q;
  logic               prev_bool_q, prev_bool_d;
  logic               tgt_bool_q, tgt_bool_d;

  // Captured event
  mcrm_in_t evt_q;

  // Mapping operands and intermediates
  logic signed [16:0]     a_q, din_q;
  logic signed [32:0]     dout_q;
  logic signed [33:0]     plo_q, phi_q;
  logic signed [NumW-1:0] num_q;
  logic [NumW-1:0]        dvd_q, quo_q;
  logic [15:0]            dsr_q, rem_q;
  logic                   neg_q, din_zero_q;
  logic [DivCntW-1:0]     cnt_q;
  logic signed [NumW:0]   qs_q;
  logic signed [NumW+1:0] res_q;
  logic signed [31:0]     mapped_q;

  // Output register
  logic      out_valid_q;
  mcrm_out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_low_q     <= RstOutLow;
      out_high_q    <= RstOutHigh;
      mode_q        <= RstOutputMode;
      act_in_low_q  <= RstInLow;
      act_in_high_q <= RstInHigh;
      act_type_q    <= RstMatchType;
      act_channel_q <= RstMatchChannel;
      act_number_q  <= RstMatchNumber;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgInLow:        act_in_low_q  <= cfg_data_i[15:0];
        CfgInHigh:       act_in_high_q <= cfg_data_i[15:0];
        CfgOutLow:       out_low_q     <= $signed(cfg_data_i);
        CfgOutHigh:      out_high_q    <= $signed(cfg_data_i);
        CfgMatchType:    act_type_q    <= cfg_data_i[1:0];
        CfgMatchChannel: act_channel_q <= cfg_data_i[4:0];
        CfgMatchNumber:  act_number_q  <= cfg_data_i[6:0];
        CfgOutputMode:   mode_q        <= cfg_data_i[2:0];
        default: ;
      endcase
    end else if (cmd_i.learn && act_type_q == MatchLearn && evt_q.command != CmdNoteOff) begin
      // take the match from this event and reset the input range
      act_channel_q <= evt_q.midi_channel;
      act_in_low_q  <= '0;
      if (evt_q.command == CmdPitch) begin
        act_type_q    <= MatchPitch;
        act_number_q  <= '0;
        act_in_high_q <= LearnHighPitch;
      end else begin
        act_type_q    <= (evt_q.command == CmdCtl) ? MatchCtl : MatchNote;
        act_number_q  <= evt_q.note_or_controller;
        act_in_high_q <= LearnHighCtl;
      end
    end
  end

  // Match against the active settings
  logic [1:0] want_type;
  always_comb begin
    case (evt_q.command)
      CmdCtl:   want_type = MatchCtl;
      CmdPitch: want_type = MatchPitch;
      default:  want_type = MatchNote;
    endcase
  end

  assign stat_o.hit = (act_type_q == want_type)
                   && (act_channel_q == '0 || evt_q.midi_channel == act_channel_q)
                   && (evt_q.command == CmdPitch || evt_q.note_or_controller == act_number_q);

  // Two-bit restoring division step
  logic [16:0] t1, t2;
  logic [15:0] r1, r2;
  logic        ge1, ge2;
  always_comb begin
    t1  = {rem_q, dvd_q[NumW-1]};
    ge1 = t1 >= {1'b0, dsr_q};
    r1  = ge1 ? 16'(t1 - {1'b0, dsr_q}) : t1[15:0];
    t2  = {r1, dvd_q[NumW-2]};
    ge2 = t2 >= {1'b0, dsr_q};
    r2  = ge2 ? 16'(t2 - {1'b0, dsr_q}) : t2[15:0];
  end

  // Clamp bounds
  logic signed [31:0]     mn, mx;
  logic signed [NumW+1:0] mn_w, mx_w;
  always_comb begin
    mn   = (out_low_q < out_high_q) ? out_low_q : out_high_q;
    mx   = (out_low_q < out_high_q) ? out_high_q : out_low_q;
    mn_w = {{(NumW-30){mn[31]}}, mn};
    mx_w = {{(NumW-30){mx[31]}}, mx};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) evt_q <= in_data_i;
    if (cmd_i.load_ops) begin
      a_q    <= $signed({1'b0, evt_q.event_value}) - $signed({1'b0, act_in_low_q});
      din_q  <= $signed({1'b0, act_in_high_q}) - $signed({1'b0, act_in_low_q});
      dout_q <= {out_high_q[31], out_high_q} - {out_low_q[31], out_low_q};
    end
    if (cmd_i.mul_lo) plo_q <= a_q * $signed({1'b0, dout_q[15:0]});
    if (cmd_i.mul_hi) phi_q <= a_q * $signed(dout_q[32:16]);
    if (cmd_i.sum) begin
      num_q <= $signed({phi_q[NumW-17:0], 16'b0})
             + $signed({{(NumW-34){plo_q[33]}}, plo_q});
    end
    if (cmd_i.div_init) begin
      dvd_q      <= num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);
      dsr_q      <= din_q[16] ? 16'(-din_q) : din_q[15:0];
      neg_q      <= num_q[NumW-1] ^ din_q[16];
      din_zero_q <= (din_q == '0);
      rem_q      <= '0;
      quo_q      <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[NumW-3:0], 2'b00};
      quo_q <= {quo_q[NumW-3:0], ge1, ge2};
      rem_q <= r2;
    end
    if (cmd_i.negate) begin
      if (din_zero_q)  qs_q <= '0;
      else if (neg_q)  qs_q <= -$signed({1'b0, quo_q});
      else             qs_q <= $signed({1'b0, quo_q});
    end
    if (cmd_i.add) res_q <= $signed({{(NumW-30){out_low_q[31]}}, out_low_q})
                          + $signed({qs_q[NumW], qs_q});
    if (cmd_i.clamp) begin
      if (res_q < mn_w)      mapped_q <= mn;
      else if (res_q > mx_w) mapped_q <= mx;
      else                   mapped_q <= res_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign stat_o.div_last = (cnt_q == DivLast);

  // Result decision
  logic      b_val, emit;
  mcrm_out_t res_out;
  always_comb begin
    if (mode_q inside {ModeBoolAny, ModeTogAny})      b_val = (mapped_q != 0);
    else if (mode_q inside {ModeBoolPos, ModeTogPos}) b_val = (mapped_q > 0);
    else                                              b_val = (mapped_q >= OneQ16);
    emit                 = 1'b0;
    prev_bool_d          = prev_bool_q;
    tgt_bool_d           = tgt_bool_q;
    res_out.number_value = mapped_q;
    res_out.write_kind   = KindBool;
    res_out.bool_value   = 1'b0;
    case (mode_q)
      ModeNumber: begin
        emit               = 1'b1;
        res_out.write_kind = KindNumber;
      end
      ModeTrigger: begin
        emit               = (mapped_q > 0);
        res_out.write_kind = KindTrigger;
      end
      ModeBoolAny, ModeBoolPos, ModeBoolOne: begin
        emit               = 1'b1;
        prev_bool_d        = b_val;
        tgt_bool_d         = b_val;
        res_out.bool_value = b_val;
      end
      default: begin
        // toggle on a rising edge only
        prev_bool_d = b_val;
        if (b_val && !prev_bool_q) begin
          emit               = 1'b1;
          tgt_bool_d         = !tgt_bool_q;
          res_out.bool_value = !tgt_bool_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_bool_q <= 1'b0;
      tgt_bool_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        prev_bool_q <= prev_bool_d;
        tgt_bool_q  <= tgt_bool_d;
      end
      if (cmd_i.commit && emit) out_valid_q <= 1'b1;
      else if (out_ready_i)     out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && emit) out_data_q <= res_out;
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

  // A waiting result never gets overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over a pending transaction");

  // A learn step always leaves a concrete match behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.learn && evt_q.command != CmdNoteOff && !cfg_we_i) |=> act_type_q != MatchLearn)
    else $error("learn left the block in learn mode");

  // Pending number stays inside the output range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.number_value >= mn && out_data_q.number_value <= mx))
    else $error("mapped value outside the output range");

  // Triggers carry a positive value, non-boolean kinds carry a zero flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.write_kind != KindBool) |->
      (!out_data_q.bool_value
       && (out_data_q.write_kind != KindTrigger || out_data_q.number_value > 0)))
    else $error("malformed trigger or number result");

endmodule

@@ src/midi_control_range_mapper.sv @@
// Top level of the MIDI control range mapper: ports, controller and datapath.
// Depends on mcrm_pkg, mcrm_ctrl and mcrm_dp.
`timescale 1ns / 1ps

// Takes one MIDI event per input transaction, filters it against the active match
// (type, channel, number; channel 0 matches all, learn mode adopts the next note on,
// control change or pitch wheel event), maps the value linearly into the Q16.16 output
// range with clamping, and returns at most one result: a number write, a trigger pulse
// or a boolean write. One event is worked on at a time. A dropped event frees the input
// after the learn and check states; a matched event goes through the two-pass 17x33
// multiply and the radix-4 divider that forms (value - in_low) * (out_high - out_low) /
// (in_high - in_low) before its result enters the output register, once that is free.
// The next event is accepted while a result still waits on the output. Configuration
// writes are taken in any cycle but may only be issued while no event is in flight.
module midi_control_range_mapper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mcrm_pkg::mcrm_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mcrm_pkg::mcrm_out_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mcrm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mcrm_pkg::CfgDataW-1:0] cfg_data_i
);
  import mcrm_pkg::*;

  mcrm_cmd_t  cmd;
  mcrm_stat_t stat;

  assign cfg_ready_o = 1'b1;

  mcrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mcrm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
